// File: src/binary_max_heap_queue_defines.svh
// ----------------------------------------------------------------------------
// Binary max-heap queue assertion macros
// Shared concurrent assertion forms for the heap queue RTL. In synthesis the
// macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define BMHQ_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("heap queue check failed");

// An antecedent that requires a consequent in the same cycle.
`define BMHQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heap queue check failed");

// An antecedent that requires a consequent in the following cycle.
`define BMHQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heap queue check failed");

`else

`define BMHQ_ASSERT_ALWAYS(label, clk, rst, cond)
`define BMHQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BMHQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// Binary max-heap queue package
// Key type, operation codes and status codes shared by the heap queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

   localparam int KEY_W = 32;

   typedef logic signed [KEY_W-1:0] key_type;

   // Operation carried by each request word.
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_APPEND = 2'd2,
      OP_BUILD  = 2'd3
   } op_type;

   // Status returned with each response word.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   localparam key_type UNDERFLOW_KEY = -32'sd1;
   localparam key_type ZERO_KEY      = '0;

endpackage

`default_nettype wire

// File: src/bmhq_store.sv
// ----------------------------------------------------------------------------
// Heap key store
// Single-port-write, single-port-read memory holding the heap keys at
// positions one to capacity. Read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmhq_store
   import bmhq_pkg::*;
#(
   parameter int DEPTH = 129,
   parameter int AW    = 8
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire key_type       wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output key_type            rd_data
);

   key_type mem [DEPTH];
   key_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the read address is always live.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/bmhq_cmp.sv
// ----------------------------------------------------------------------------
// Heap key comparator
// Shared signed compare-and-select unit. The challenger replaces the incumbent
// only when it is strictly larger.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmhq_cmp
   import bmhq_pkg::*;
(
   input  wire key_type incumbent,
   input  wire key_type challenger,
   output logic         challenger_wins,
   output key_type      max_key
);

   // Strict signed comparison keeps ties with the incumbent.
   always_comb begin
      challenger_wins = (challenger > incumbent);
      max_key         = challenger_wins ? challenger : incumbent;
   end

endmodule

`default_nettype wire

// File: src/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// Binary max-heap queue
// Priority queue of signed 32-bit keys with insert, delete-max, raw append and
// build-heap operations, one response word per request word.
// ----------------------------------------------------------------------------
// The block takes one request word at a time and holds req_ready low until
// that word's work is finished; the response waits in an output register, so
// a new request may be taken before the previous response has been collected.
// All work goes through one key memory (one write and one registered read a
// cycle) and one shared signed comparator under a small sequencer. A response
// still waiting in the output register holds the block in its final state.
// Append, a build of fewer than two elements and any full or empty case go
// from the decode straight to the final state. Insert climbs from the new
// leaf, reading each parent and moving it down while the key is strictly
// larger, and writes the key where it stops. Delete-max reads the root and
// the last element, then sifts that element down from the root: each level
// reads the left child and weighs it, reads the right child if present and
// weighs that, then promotes the larger child or settles the key. Build runs
// one such descent per internal node, from the last internal node back to
// the root, fetching each node's key first, and sends its response after the
// descent from the root.
// There is no clearing pass after reset: positions beyond the element count
// are never read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "binary_max_heap_queue_defines.svh"

module binary_max_heap_queue
   import bmhq_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire key_type     req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output key_type          rsp_result_value,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_count_after
);

   // Position and count width: positions run from one to CAPACITY.
   localparam int PW = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SU_RD,
      S_SU_CMP,
      S_DEL_ROOT,
      S_DEL_LAST,
      S_BLD_RD,
      S_BLD_KEY,
      S_SD_RDL,
      S_SD_RDR,
      S_SD_CMPR,
      S_SD_MOVE,
      S_FIN
   } state_type;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [PW-1:0]    count_ff, count_in;
   logic [PW-1:0]    node_ff, node_in;
   logic [PW-1:0]    k_ff, k_in;
   logic [PW-1:0]    best_pos_ff, best_pos_in;
   key_type          key_ff, key_in;
   key_type          best_key_ff, best_key_in;
   key_type          res_ff, res_in;
   status_type       status_ff, status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   key_type          rsp_res_ff, rsp_res_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [PW-1:0]    rsp_cnt_ff, rsp_cnt_in;

   // Memory and comparator hook-up.
   logic             wr_en;
   logic [PW-1:0]    wr_addr;
   key_type          wr_data;
   logic [PW-1:0]    rd_addr;
   key_type          rd_data;
   key_type          cmp_incumbent;
   key_type          cmp_challenger;
   logic             cmp_wins;
   key_type          cmp_max;

   // Child positions of the current node, one bit wider than a position.
   logic [PW:0]      left_pos;
   logic [PW:0]      right_pos;
   logic [PW:0]      count_wide;
   logic             more_build;
   logic             accept;
   logic             rsp_free;
   logic [PW+7:0]    cnt_ext;

   bmhq_store #(
      .DEPTH (CAPACITY + 1),
      .AW    (PW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bmhq_cmp u_cmp (
      .incumbent       (cmp_incumbent),
      .challenger      (cmp_challenger),
      .challenger_wins (cmp_wins),
      .max_key         (cmp_max)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign left_pos   = {node_ff, 1'b0};
   assign right_pos  = {node_ff, 1'b1};
   assign count_wide = {1'b0, count_ff};
   assign more_build = (op_ff == OP_BUILD) && (k_ff > PW'(1));

   // Comparator operand selection: sift-up compares the new key against its
   // parent, sift-down compares each child against the current best.
   always_comb begin
      case (state_ff)
         S_SU_CMP: begin
            cmp_incumbent  = rd_data;
            cmp_challenger = key_ff;
         end
         S_SD_RDR: begin
            cmp_incumbent  = key_ff;
            cmp_challenger = rd_data;
         end
         default: begin
            cmp_incumbent  = best_key_ff;
            cmp_challenger = rd_data;
         end
      endcase
   end

   // Sequencer next-state and datapath logic.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      count_in      = count_ff;
      node_in       = node_ff;
      k_in          = k_ff;
      best_pos_in   = best_pos_ff;
      key_in        = key_ff;
      best_key_in   = best_key_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_res_in    = rsp_res_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      wr_en         = 1'b0;
      wr_addr       = node_ff;
      wr_data       = key_ff;
      rd_addr       = node_ff;

      case (state_ff)
         // Decode a new request word.
         S_IDLE: begin
            if (accept) begin
               op_in     = op_type'(req_operation);
               res_in    = ZERO_KEY;
               status_in = ST_OK;
               case (op_type'(req_operation))
                  OP_INSERT, OP_APPEND: begin
                     if (count_ff == PW'(CAPACITY)) begin
                        status_in = ST_OVERFLOW;
                        state_in  = S_FIN;
                     end else if (op_type'(req_operation) == OP_APPEND) begin
                        count_in = count_ff + PW'(1);
                        wr_en    = 1'b1;
                        wr_addr  = count_ff + PW'(1);
                        wr_data  = req_value;
                        state_in = S_FIN;
                     end else begin
                        count_in = count_ff + PW'(1);
                        node_in  = count_ff + PW'(1);
                        key_in   = req_value;
                        state_in = S_SU_RD;
                     end
                  end
                  OP_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = ST_UNDERFLOW;
                        res_in    = UNDERFLOW_KEY;
                        state_in  = S_FIN;
                     end else begin
                        rd_addr  = PW'(1);
                        state_in = S_DEL_ROOT;
                     end
                  end
                  default: begin
                     k_in = count_ff >> 1;
                     if ((count_ff >> 1) == '0) begin
                        state_in = S_FIN;
                     end else begin
                        state_in = S_BLD_RD;
                     end
                  end
               endcase
            end
         end

         // Sift-up: fetch the parent of the hole, or write the key if the hole is the root.
         S_SU_RD: begin
            if (node_ff == PW'(1)) begin
               wr_en    = 1'b1;
               state_in = S_FIN;
            end else begin
               rd_addr  = node_ff >> 1;
               state_in = S_SU_CMP;
            end
         end

         // Sift-up: move the parent down if the new key is strictly larger, else write the key here.
         S_SU_CMP: begin
            wr_en = 1'b1;
            if (cmp_wins) begin
               wr_data  = rd_data;
               node_in  = node_ff >> 1;
               state_in = S_SU_RD;
            end else begin
               state_in = S_FIN;
            end
         end

         // Delete: capture the root and fetch the last element.
         S_DEL_ROOT: begin
            res_in   = rd_data;
            rd_addr  = count_ff;
            state_in = S_DEL_LAST;
         end

         // Delete: the last element becomes the key sifted down from the root.
         S_DEL_LAST: begin
            key_in   = rd_data;
            count_in = count_ff - PW'(1);
            node_in  = PW'(1);
            state_in = S_SD_RDL;
         end

         // Build: fetch the key of the next internal node.
         S_BLD_RD: begin
            rd_addr  = k_ff;
            state_in = S_BLD_KEY;
         end

         S_BLD_KEY: begin
            key_in   = rd_data;
            node_in  = k_ff;
            state_in = S_SD_RDL;
         end

         // Sift-down: fetch the left child, or settle the key at a leaf.
         S_SD_RDL: begin
            if (left_pos > count_wide) begin
               wr_en = 1'b1;
               if (more_build) begin
                  k_in     = k_ff - PW'(1);
                  state_in = S_BLD_RD;
               end else begin
                  state_in = S_FIN;
               end
            end else begin
               rd_addr  = left_pos[PW-1:0];
               state_in = S_SD_RDR;
            end
         end

         // Sift-down: weigh the left child and fetch the right one if present.
         S_SD_RDR: begin
            best_key_in = cmp_max;
            best_pos_in = cmp_wins ? left_pos[PW-1:0] : node_ff;
            if (right_pos > count_wide) begin
               state_in = S_SD_MOVE;
            end else begin
               rd_addr  = right_pos[PW-1:0];
               state_in = S_SD_CMPR;
            end
         end

         // Sift-down: the right child wins only if strictly larger.
         S_SD_CMPR: begin
            best_key_in = cmp_max;
            if (cmp_wins) begin
               best_pos_in = right_pos[PW-1:0];
            end
            state_in = S_SD_MOVE;
         end

         // Sift-down: promote the larger child or settle the key here.
         S_SD_MOVE: begin
            wr_en = 1'b1;
            if (best_pos_ff != node_ff) begin
               wr_data  = best_key_ff;
               node_in  = best_pos_ff;
               state_in = S_SD_RDL;
            end else if (more_build) begin
               k_in     = k_ff - PW'(1);
               state_in = S_BLD_RD;
            end else begin
               state_in = S_FIN;
            end
         end

         // Hand the response word to the output register once it is free.
         S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_res_in    = res_ff;
               rsp_status_in = status_ff;
               rsp_cnt_in    = count_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, datapath registers and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      node_ff       <= node_in;
      k_ff          <= k_in;
      best_pos_ff   <= best_pos_in;
      key_ff        <= key_in;
      best_key_ff   <= best_key_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   // The reported count carries the low eight bits of the element count.
   assign cnt_ext          = (PW + 8)'(rsp_cnt_ff);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_res_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_count_after  = cnt_ext[7:0];

   // The element count never passes the capacity.
   `BMHQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= PW'(CAPACITY))
   // The count only moves while a request word is being worked on.
   `BMHQ_ASSERT_NEXT(a_count_idle, clock, reset, state_ff == S_IDLE && !accept, $stable(count_ff))
   // A node being sifted lies inside the live part of the heap. A delete that
   // empties the store still settles its key at the root.
   `BMHQ_ASSERT_IMPL(a_node_range, clock, reset, state_ff == S_SD_RDL || state_ff == S_SU_RD, node_ff >= PW'(1) && (node_ff <= count_ff || count_ff == '0))
   // Overflow is reported only against a full store.
   `BMHQ_ASSERT_IMPL(a_overflow_full, clock, reset, rsp_valid_ff && rsp_status_ff == ST_OVERFLOW, rsp_cnt_ff == PW'(CAPACITY))
   // Underflow is reported only against an empty store, with the fixed value.
   `BMHQ_ASSERT_IMPL(a_underflow_val, clock, reset, rsp_valid_ff && rsp_status_ff == ST_UNDERFLOW, rsp_res_ff == UNDERFLOW_KEY && rsp_cnt_ff == '0)

endmodule

`default_nettype wire
